>>> hw/rtl/uart_8n1_tick_transceiver_macros.svh
// ----------------------------------------------------------------------------
// uart 8n1 tick transceiver assertion macros
// shared concurrent assertion forms for the checker
// ----------------------------------------------------------------------------
`ifndef UART_8N1_TICK_TRANSCEIVER_MACROS_SVH
`define UART_8N1_TICK_TRANSCEIVER_MACROS_SVH

// same-cycle implication, off during reset
`define U8TT_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("u8tt assertion failed");

// next-cycle implication, off during reset
`define U8TT_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("u8tt assertion failed");

// next-cycle implication, checked during reset too
`define U8TT_ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("u8tt assertion failed");

`endif

>>> hw/rtl/u8tt_pkg.sv
// ----------------------------------------------------------------------------
// u8tt_pkg
// types, phase codes and widths shared by the uart 8n1 tick transceiver
// ----------------------------------------------------------------------------
package u8tt_pkg;

    localparam int DIV_W = 16;
    localparam int CNT_W = DIV_W + 1;

    localparam logic [3:0] BITS_PER_FRAME = 4'd8;

    localparam logic [2:0] PH_IDLE  = 3'd0;
    localparam logic [2:0] PH_START = 3'd1;
    localparam logic [2:0] PH_BITS  = 3'd2;
    localparam logic [2:0] PH_WAIT  = 3'd3;
    localparam logic [2:0] PH_STOP  = 3'd4;

    typedef logic [DIV_W-1:0] t_div;
    typedef logic [CNT_W-1:0] t_cnt;

    typedef struct packed {
        logic       tx_byte_valid;
        logic [7:0] tx_byte;
        logic       tx_enable;
        logic       rx_line;
        logic       rx_enable;
    } t_in_item;

    typedef struct packed {
        logic       line_out;
        logic       tx_pop;
        logic       rx_valid;
        logic [7:0] rx_byte;
    } t_out_item;

endpackage

>>> hw/rtl/u8tt_tx.sv
// ----------------------------------------------------------------------------
// u8tt_tx
// transmit machine: start bit, eight data bits lsb first, stop level
// ----------------------------------------------------------------------------
module u8tt_tx (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_step,
    input  u8tt_pkg::t_div    i_div,
    input  u8tt_pkg::t_in_item i_item,
    output logic              o_line_out,
    output logic              o_tx_pop
);

    logic [2:0]     r_phase, n_phase;
    u8tt_pkg::t_cnt r_cnt, n_cnt;
    logic [3:0]     r_idx, n_idx;
    logic           r_line, n_line;
    logic           w_pop;

    u8tt_pkg::t_cnt w_bump;
    u8tt_pkg::t_cnt w_div1;
    u8tt_pkg::t_cnt w_div2;
    logic [3:0]     w_idx_inc;
    logic           w_div_gt1;
    logic           w_bit;

    assign w_bump    = r_cnt + u8tt_pkg::t_cnt'(1);
    assign w_div1    = {1'b0, i_div};
    assign w_div2    = {i_div, 1'b0};
    assign w_idx_inc = r_idx + 4'd1;
    assign w_div_gt1 = (i_div > u8tt_pkg::t_div'(1));
    assign w_bit     = i_item.tx_byte[r_idx[2:0]];

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_line  = r_line;
        w_pop   = 1'b0;
        unique case (r_phase)
            u8tt_pkg::PH_IDLE: begin
                if (i_item.tx_byte_valid && i_item.tx_enable) begin
                    n_line  = 1'b0;
                    n_idx   = 4'd0;
                    n_phase = w_div_gt1 ? u8tt_pkg::PH_START : u8tt_pkg::PH_BITS;
                    n_cnt   = w_bump;
                end
            end
            u8tt_pkg::PH_START: begin
                n_cnt = w_bump;
                if (w_bump >= w_div1) begin
                    n_line  = w_bit;
                    n_idx   = w_idx_inc;
                    n_cnt   = '0;
                    n_phase = u8tt_pkg::PH_WAIT;
                end
            end
            u8tt_pkg::PH_BITS: begin
                n_line = w_bit;
                n_idx  = w_idx_inc;
                n_cnt  = '0;
                if (w_div_gt1) begin
                    n_phase = u8tt_pkg::PH_WAIT;
                end else if (w_idx_inc >= u8tt_pkg::BITS_PER_FRAME) begin
                    n_phase = u8tt_pkg::PH_STOP;
                    w_pop   = 1'b1;
                end
            end
            u8tt_pkg::PH_WAIT: begin
                n_cnt = w_bump;
                if (w_bump >= w_div1) begin
                    n_cnt = '0;
                    if (r_idx >= u8tt_pkg::BITS_PER_FRAME) begin
                        n_phase = u8tt_pkg::PH_STOP;
                        w_pop   = 1'b1;
                    end else begin
                        n_phase = u8tt_pkg::PH_BITS;
                    end
                end
            end
            u8tt_pkg::PH_STOP: begin
                n_line = 1'b1;
                n_cnt  = w_bump;
                if (w_bump >= w_div2) begin
                    n_phase = u8tt_pkg::PH_IDLE;
                    n_cnt   = '0;
                end
            end
            default: begin
                n_phase = u8tt_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u8tt_pkg::PH_IDLE;
            r_cnt   <= '0;
            r_idx   <= 4'd0;
            r_line  <= 1'b1;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_line  <= n_line;
        end
    end

    assign o_line_out = n_line;
    assign o_tx_pop   = w_pop;

endmodule

>>> hw/rtl/u8tt_rx.sv
// ----------------------------------------------------------------------------
// u8tt_rx
// receive machine: start detect, eight samples lsb first, stop wait
// ----------------------------------------------------------------------------
module u8tt_rx (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_step,
    input  u8tt_pkg::t_div     i_div,
    input  u8tt_pkg::t_in_item i_item,
    output logic               o_rx_valid,
    output logic [7:0]         o_rx_byte
);

    logic [2:0]     r_phase, n_phase;
    u8tt_pkg::t_cnt r_cnt, n_cnt;
    logic [3:0]     r_idx, n_idx;
    logic [7:0]     r_shift, n_shift;
    logic           w_valid;
    logic [7:0]     w_byte;

    u8tt_pkg::t_cnt w_bump;
    u8tt_pkg::t_cnt w_div1;
    u8tt_pkg::t_cnt w_div2;
    logic [3:0]     w_idx_inc;
    logic           w_div_is1;

    assign w_bump    = r_cnt + u8tt_pkg::t_cnt'(1);
    assign w_div1    = {1'b0, i_div};
    assign w_div2    = {i_div, 1'b0};
    assign w_idx_inc = r_idx + 4'd1;
    assign w_div_is1 = (i_div == u8tt_pkg::t_div'(1));

    always_comb begin
        n_phase = r_phase;
        n_cnt   = r_cnt;
        n_idx   = r_idx;
        n_shift = r_shift;
        w_valid = 1'b0;
        w_byte  = 8'd0;
        unique case (r_phase)
            u8tt_pkg::PH_IDLE: begin
                if (!i_item.rx_line && i_item.rx_enable) begin
                    n_shift = 8'd0;
                    if (w_div_is1) begin
                        n_phase = u8tt_pkg::PH_BITS;
                        n_idx   = 4'd0;
                    end else begin
                        n_cnt   = u8tt_pkg::t_cnt'(1);
                        n_phase = u8tt_pkg::PH_START;
                    end
                end
            end
            u8tt_pkg::PH_START: begin
                n_cnt = w_bump;
                if (w_bump >= w_div1) begin
                    n_phase = u8tt_pkg::PH_BITS;
                    n_idx   = 4'd0;
                    n_cnt   = '0;
                end
            end
            u8tt_pkg::PH_BITS: begin
                n_shift[r_idx[2:0]] = i_item.rx_line;
                n_idx = w_idx_inc;
                if (w_div_is1) begin
                    if (w_idx_inc >= u8tt_pkg::BITS_PER_FRAME) begin
                        n_cnt   = '0;
                        n_phase = u8tt_pkg::PH_STOP;
                    end
                end else begin
                    n_cnt   = u8tt_pkg::t_cnt'(1);
                    n_phase = u8tt_pkg::PH_WAIT;
                end
            end
            u8tt_pkg::PH_WAIT: begin
                n_cnt = w_bump;
                if (w_bump >= w_div1) begin
                    n_cnt   = '0;
                    n_phase = (r_idx >= u8tt_pkg::BITS_PER_FRAME) ?
                              u8tt_pkg::PH_STOP : u8tt_pkg::PH_BITS;
                end
            end
            u8tt_pkg::PH_STOP: begin
                n_cnt = w_bump;
                if (w_bump >= w_div2) begin
                    n_phase = u8tt_pkg::PH_IDLE;
                    w_valid = 1'b1;
                    w_byte  = r_shift;
                    n_shift = 8'd0;
                end
            end
            default: begin
                n_phase = u8tt_pkg::PH_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= u8tt_pkg::PH_IDLE;
            r_cnt   <= '0;
            r_idx   <= 4'd0;
            r_shift <= 8'd0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_cnt   <= n_cnt;
            r_idx   <= n_idx;
            r_shift <= n_shift;
        end
    end

    assign o_rx_valid = w_valid;
    assign o_rx_byte  = w_byte;

endmodule

>>> hw/rtl/u8tt_skid.sv
// ----------------------------------------------------------------------------
// u8tt_skid
// result register with one skid entry between the two handshake sides
// ----------------------------------------------------------------------------
module u8tt_skid (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_in_valid,
    input  u8tt_pkg::t_out_item i_in_data,
    output logic                o_in_ready,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output u8tt_pkg::t_out_item o_out_data
);

    logic                r_out_valid;
    u8tt_pkg::t_out_item r_out_data;
    logic                r_skid_valid;
    u8tt_pkg::t_out_item r_skid_data;

    logic w_take;
    logic w_put;

    assign o_in_ready = !r_skid_valid;
    assign w_take     = r_out_valid && i_out_ready;
    assign w_put      = i_in_valid && !r_skid_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else if (r_skid_valid) begin
            if (w_take) begin
                r_skid_valid <= 1'b0;
            end
        end else if (w_put) begin
            if (!r_out_valid || w_take) begin
                r_out_valid <= 1'b1;
            end else begin
                r_skid_valid <= 1'b1;
            end
        end else if (w_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_valid) begin
            if (w_take) begin
                r_out_data <= r_skid_data;
            end
        end else if (w_put) begin
            if (!r_out_valid || w_take) begin
                r_out_data <= i_in_data;
            end else begin
                r_skid_data <= i_in_data;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule

>>> hw/rtl/uart_8n1_tick_transceiver.sv
// ----------------------------------------------------------------------------
// uart_8n1_tick_transceiver
// Each request is one tick of the serial timebase and yields exactly one
// result request, registered when it is accepted. A new request is accepted
// every cycle: the transmit and receive machines each update in a single pass
// of logic, and their combined result goes into a result register backed by
// one skid entry, so the input side stalls only once two results are waiting.
// The divider register write is always accepted; a divider of zero acts as one.
// ----------------------------------------------------------------------------
module uart_8n1_tick_transceiver (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  u8tt_pkg::t_div      i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  u8tt_pkg::t_in_item  i_in_data,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output u8tt_pkg::t_out_item o_out_data
);

    u8tt_pkg::t_div      r_div;
    u8tt_pkg::t_div      w_div;
    logic                w_step;
    u8tt_pkg::t_out_item w_result;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_div <= u8tt_pkg::t_div'(1);
        end else if (i_cfg_valid) begin
            r_div <= i_cfg_data;
        end
    end

    assign w_div  = (r_div == '0) ? u8tt_pkg::t_div'(1) : r_div;
    assign w_step = i_in_valid && o_in_ready;

    u8tt_tx u_tx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_div      (w_div),
        .i_item     (i_in_data),
        .o_line_out (w_result.line_out),
        .o_tx_pop   (w_result.tx_pop)
    );

    u8tt_rx u_rx (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (w_step),
        .i_div      (w_div),
        .i_item     (i_in_data),
        .o_rx_valid (w_result.rx_valid),
        .o_rx_byte  (w_result.rx_byte)
    );

    u8tt_skid u_skid (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_in_data   (w_result),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_data  (o_out_data)
    );

endmodule

>>> hw/rtl/u8tt_checker.sv
// ----------------------------------------------------------------------------
// u8tt_checker
// port-level checks for the uart 8n1 tick transceiver
// ----------------------------------------------------------------------------
`include "uart_8n1_tick_transceiver_macros.svh"

module u8tt_checker (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_in_valid,
    input logic                o_in_ready,
    input logic                o_out_valid,
    input logic                i_out_ready,
    input u8tt_pkg::t_out_item o_out_data
);

    // no result right after reset
    `U8TT_ASSERT_NEXT_ALWAYS(a_reset_empty, i_clk, !i_rst_n, !o_out_valid)

    // input stalls only when a result is already waiting
    `U8TT_ASSERT_NOW(a_stall_needs_result, i_clk, i_rst_n, !o_in_ready, o_out_valid)

    // an accepted request always shows a result next cycle
    `U8TT_ASSERT_NEXT(a_accept_gives_result, i_clk, i_rst_n, i_in_valid && o_in_ready, o_out_valid)

    // rx byte is zero unless a byte completes
    `U8TT_ASSERT_NOW(a_rx_byte_zero, i_clk, i_rst_n, o_out_valid && !o_out_data.rx_valid, o_out_data.rx_byte == 8'd0)

    // a stalled result holds
    `U8TT_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_out_data))

endmodule

bind uart_8n1_tick_transceiver u8tt_checker u_u8tt_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_in_valid  (i_in_valid),
    .o_in_ready  (o_in_ready),
    .o_out_valid (o_out_valid),
    .i_out_ready (i_out_ready),
    .o_out_data  (o_out_data)
);
